/* rtl/spq_pkg.sv */
// shared types, constants and pointer helpers for the sorted priority queue
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 16;
    localparam int FILL_W  = 5;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic signed [RANK_W-1:0]  rank;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PLACE,
        ST_POP
    } state_t;

    function automatic addr_t ptr_inc(input addr_t p);
        return (p == ADDR_W'(DEPTH - 1)) ? ADDR_W'(0) : p + ADDR_W'(1);
    endfunction

    function automatic addr_t ptr_dec(input addr_t p);
        return (p == ADDR_W'(0)) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
    endfunction

    // circular add of a count to a pointer, count never above DEPTH
    function automatic addr_t ptr_add(input addr_t p, input cnt_t c);
        logic [ADDR_W:0] s;
        s = {1'b0, p} + (ADDR_W + 1)'(c);
        if (s >= (ADDR_W + 1)'(DEPTH))
        begin
            s = s - (ADDR_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/spq_ram.sv */
// simple dual port ram, one write and one registered read per cycle
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/sorted_priority_queue.sv */
// sorted priority queue: circular buffer in ram, insert by backward walk from the tail
// result: the result word is strobed on done in the cycle after the item's last busy cycle
// remove reads the head while busy; insert does one ram read per entry examined from the tail,
// then a place step if all rank higher; full insert, empty remove and insert into empty never go busy
// handshake: a new word is taken whenever busy is low, also in the cycle done is shown
// reset: head, count and control clear at once; ram contents stay undefined, no clear pass
module sorted_priority_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
    input  logic signed [spq_pkg::RANK_W-1:0]  item_rank,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [spq_pkg::VALUE_W-1:0] out_value,
    output logic signed [spq_pkg::RANK_W-1:0]  out_rank,
    output logic [spq_pkg::FILL_W-1:0]         fill
);

    import spq_pkg::*;

    // control state
    state_t state_reg, state_next;
    addr_t  head_reg, head_next;      // physical slot of the lowest rank
    cnt_t   count_reg, count_next;    // stored entries
    addr_t  rd_ptr_reg, rd_ptr_next;  // slot whose data arrives from the ram
    addr_t  wr_ptr_reg, wr_ptr_next;  // hole opened by the walk
    cnt_t   remain_reg, remain_next;  // entries still to examine, incl. the one in flight
    logic   done_reg, done_next;

    // payload
    logic signed [VALUE_W-1:0] item_value_reg;
    logic signed [RANK_W-1:0]  item_rank_reg;
    status_t                   status_reg, res_status;
    logic signed [VALUE_W-1:0] out_value_reg, res_value;
    logic signed [RANK_W-1:0]  out_rank_reg, res_rank;
    logic [FILL_W-1:0]         fill_reg, res_fill;
    logic                      cap_en;

    // ram port
    logic   mem_wr_en, mem_rd_en;
    addr_t  mem_wr_addr, mem_rd_addr, tail;
    entry_t mem_wr_data, rd_entry, new_entry;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_entry)
    );

    assign tail      = ptr_add(head_reg, count_reg);
    assign new_entry = '{rank: item_rank_reg, value: item_value_reg};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        remain_next = remain_reg;
        done_next   = 1'b0;
        cap_en      = 1'b0;
        res_status  = STATUS_DONE;
        res_value   = '0;
        res_rank    = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_ptr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wr_ptr_reg;
        mem_wr_data = new_entry;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cap_en = 1'b1;
                    if (op == OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            // full, drop the word
                            done_next  = 1'b1;
                            res_status = STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty queue, write straight to the tail
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = tail;
                            mem_wr_data = '{rank: item_rank, value: item_value};
                            count_next  = count_reg + CNT_W'(1);
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            // start the walk at the last stored entry
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ptr_dec(tail);
                            rd_ptr_next = ptr_dec(tail);
                            wr_ptr_next = tail;
                            remain_next = count_reg;
                            state_next  = ST_WALK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next  = 1'b1;
                            res_status = STATUS_EMPTY;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg;
                            state_next  = ST_POP;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (rd_entry.rank > item_rank_reg)
                begin
                    // stored entry ranks higher: move it one slot back, hole moves forward
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = wr_ptr_reg;
                    mem_wr_data = rd_entry;
                    wr_ptr_next = rd_ptr_reg;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ptr_dec(rd_ptr_reg);
                        rd_ptr_next = ptr_dec(rd_ptr_reg);
                        remain_next = remain_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    // equal or lower rank stays ahead, new word fills the hole
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                // new word becomes the head
                mem_wr_en  = 1'b1;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_POP:
            begin
                res_value  = rd_entry.value;
                res_rank   = rd_entry.rank;
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - CNT_W'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_fill = FILL_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            remain_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            remain_reg <= remain_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            item_value_reg <= item_value;
            item_rank_reg  <= item_rank;
        end
        if (done_next)
        begin
            status_reg    <= res_status;
            out_value_reg <= res_value;
            out_rank_reg  <= res_rank;
            fill_reg      <= res_fill;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign out_rank  = out_rank_reg;
    assign fill      = fill_reg;

    // results are only shown while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while busy");

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    // an accepted word either finishes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done_reg || busy))
        else $error("accepted word lost");

    // the walk always has an entry in flight
    a_walk_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (remain_reg != '0))
        else $error("walk with nothing left to examine");

    // a pop always leaves with one entry less than before
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop count mismatch");

endmodule
